// File: design/fsgs_pkg.sv
package fsgs_pkg;

  localparam int GRID_COLUMNS_DEF = 64;
  localparam int GRID_ROWS_DEF    = 32;
  localparam int SLOT_COUNT       = 5;

  localparam logic [7:0] KEEP_MASK  = 8'b0100_0011;
  localparam logic [7:0] WALL_CLEAR = 8'h7f;
  localparam logic [7:0] BLOCKED    = 8'h03;
  localparam logic [3:0] WET_RESET  = 4'd6;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_SAND  = 2'd1;
  localparam logic [1:0] KIND_WATER = 2'd2;

  typedef logic [2:0] func_t;
  localparam func_t FUNC_WRITE   = 3'd0;
  localparam func_t FUNC_READ    = 3'd1;
  localparam func_t FUNC_SWEEP   = 3'd2;
  localparam func_t FUNC_CLEAR   = 3'd3;
  localparam func_t FUNC_RELEASE = 3'd4;

  // neighbour slots: below, below-left, below-right, left, right
  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_BELOW = 3'd0;
  localparam slot_t SLOT_BL    = 3'd1;
  localparam slot_t SLOT_BR    = 3'd2;
  localparam slot_t SLOT_LEFT  = 3'd3;
  localparam slot_t SLOT_RIGHT = 3'd4;
  localparam slot_t SLOT_END   = 3'd5;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CMD_WAIT,
    ST_CLR,
    ST_REL_RD,
    ST_REL_WR,
    ST_SW_RD,
    ST_SW_CHK,
    ST_SW_NB,
    ST_SW_DEC,
    ST_SW_WR,
    ST_DONE
  } state_t;

  function automatic logic [7:0] soak_value(logic [7:0] v, logic [3:0] colour);
    soak_value = (v & KEEP_MASK) | {2'b00, colour, 2'b00};
  endfunction

endpackage

// File: design/fsgs_cell_ram.sv
module fsgs_cell_ram #(
  parameter int DEPTH = fsgs_pkg::GRID_COLUMNS_DEF * fsgs_pkg::GRID_ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/falling_sand_grid_step_core.sv
// Falling-sand grid engine. Cells live in one single-port RAM (one access per
// cycle, registered read). After reset a clearing pass over all cells
// (GRID_COLUMNS*GRID_ROWS) runs before the first transaction is taken. A write
// or read passes through a wait state, clear writes each cell, release walls
// reads and then writes each cell, and a sweep visits each cell (read, check,
// six neighbour slots, decide, five write slots; an empty or wall cell stops
// after the check), all set by the single RAM port. The done state loads the
// result register; the next transaction may be taken while a result waits.
module falling_sand_grid_step_core #(
  parameter int GRID_COLUMNS = fsgs_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = fsgs_pkg::GRID_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [10:0] in_cell_index,
  input  logic [7:0]  in_cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_value,
  output logic        out_grid_empty,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wet_colour
);

  localparam int N  = GRID_COLUMNS * GRID_ROWS;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int PW = AW + 2;
  localparam logic [AW-1:0] LAST     = AW'(N - 1);
  localparam logic [AW-1:0] LAST_ROW = AW'(N - GRID_COLUMNS);

  fsgs_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]     cur_r;
  fsgs_pkg::func_t   func_r;
  logic              idx_ok_r;
  logic [AW-1:0]     idx_r;
  logic [7:0]        val_r;
  logic [CW-1:0]     count_r;
  logic [3:0]        wet_r;
  logic [7:0]        c_r;
  logic [7:0]        nb_r [fsgs_pkg::SLOT_COUNT];
  logic              nbok_r [fsgs_pkg::SLOT_COUNT];
  fsgs_pkg::slot_t   slot_r;
  logic              prev_ok_r;
  logic              mv_r;
  fsgs_pkg::slot_t   tslot_r;
  logic [7:0]        rd_r;
  logic              out_valid_r;
  logic [7:0]        out_read_value_r;
  logic              out_grid_empty_r;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  logic              accept;
  logic [31:0]       idx32;
  logic              idx_ok;
  logic              out_free;
  logic signed [PW-1:0] slot_pos;
  logic              slot_ok;
  logic signed [PW-1:0] tgt_pos;
  logic              mv;
  fsgs_pkg::slot_t   tslot;
  logic              soak_en;
  fsgs_pkg::slot_t   soak_slot;
  logic signed [PW-1:0] soak_pos;

  function automatic logic signed [PW-1:0] nb_pos(logic [AW-1:0] i, fsgs_pkg::slot_t s);
    logic signed [PW-1:0] b;
    b = $signed({2'b00, i});
    case (s)
      fsgs_pkg::SLOT_BELOW: nb_pos = b + PW'(GRID_COLUMNS);
      fsgs_pkg::SLOT_BL:    nb_pos = b + PW'(GRID_COLUMNS - 1);
      fsgs_pkg::SLOT_BR:    nb_pos = b + PW'(GRID_COLUMNS + 1);
      fsgs_pkg::SLOT_LEFT:  nb_pos = b - PW'(1);
      default:              nb_pos = b + PW'(1);
    endcase
  endfunction

  fsgs_cell_ram #(.DEPTH(N), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign in_ready = (state_r == fsgs_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx32    = 32'(in_cell_index);
  assign idx_ok   = idx32 < 32'(N);
  assign out_free = !out_valid_r || out_ready;

  assign slot_pos = nb_pos(cur_r, slot_r);
  always_comb begin
    slot_ok = (slot_pos >= 0) && (slot_pos < $signed(PW'(N)));
    if ((slot_r == fsgs_pkg::SLOT_BL || slot_r == fsgs_pkg::SLOT_BR) && !(cur_r < LAST_ROW)) begin
      slot_ok = 1'b0;
    end
  end

  always_comb begin
    mv    = 1'b0;
    tslot = fsgs_pkg::SLOT_BELOW;
    if (c_r[1:0] == fsgs_pkg::KIND_SAND) begin
      if (nb_r[0][1:0] == fsgs_pkg::KIND_EMPTY || nb_r[0][1:0] == fsgs_pkg::KIND_WATER) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_BELOW;
      end else if (nb_r[1][1:0] == fsgs_pkg::KIND_EMPTY) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_BL;
      end else if (nb_r[2][1:0] == fsgs_pkg::KIND_EMPTY) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_BR;
      end
    end else if (c_r[1:0] == fsgs_pkg::KIND_WATER) begin
      if (nb_r[0][1:0] == fsgs_pkg::KIND_EMPTY) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_BELOW;
      end else if (nb_r[1][1:0] == fsgs_pkg::KIND_EMPTY) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_BL;
      end else if (nb_r[2][1:0] == fsgs_pkg::KIND_EMPTY) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_BR;
      end else if (nb_r[3][1:0] == fsgs_pkg::KIND_EMPTY) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_LEFT;
      end else if (nb_r[4][1:0] == fsgs_pkg::KIND_EMPTY) begin
        mv = 1'b1; tslot = fsgs_pkg::SLOT_RIGHT;
      end
    end
  end

  assign tgt_pos = nb_pos(cur_r, tslot_r);

  always_comb begin
    soak_slot = fsgs_pkg::SLOT_BELOW;
    soak_en   = 1'b0;
    case (slot_r)
      fsgs_pkg::SLOT_BR: begin
        soak_slot = fsgs_pkg::SLOT_BELOW;
        soak_en   = nbok_r[0] && nb_r[0][1:0] == fsgs_pkg::KIND_SAND;
      end
      fsgs_pkg::SLOT_LEFT: begin
        soak_slot = fsgs_pkg::SLOT_LEFT;
        soak_en   = nbok_r[3] && nb_r[3][1:0] == fsgs_pkg::KIND_SAND;
      end
      fsgs_pkg::SLOT_RIGHT: begin
        soak_slot = fsgs_pkg::SLOT_RIGHT;
        soak_en   = nbok_r[4] && nb_r[4][1:0] == fsgs_pkg::KIND_SAND;
      end
      default: begin
        soak_slot = fsgs_pkg::SLOT_BELOW;
        soak_en   = 1'b0;
      end
    endcase
  end
  assign soak_pos = nb_pos(cur_r, soak_slot);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsgs_pkg::ST_INIT_CLR: if (cur_r == LAST) state_nxt = fsgs_pkg::ST_IDLE;
      fsgs_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            fsgs_pkg::FUNC_WRITE, fsgs_pkg::FUNC_READ: state_nxt = fsgs_pkg::ST_CMD_WAIT;
            fsgs_pkg::FUNC_SWEEP:   state_nxt = fsgs_pkg::ST_SW_RD;
            fsgs_pkg::FUNC_CLEAR:   state_nxt = fsgs_pkg::ST_CLR;
            fsgs_pkg::FUNC_RELEASE: state_nxt = fsgs_pkg::ST_REL_RD;
            default:                state_nxt = fsgs_pkg::ST_DONE;
          endcase
        end
      end
      fsgs_pkg::ST_CMD_WAIT: state_nxt = fsgs_pkg::ST_DONE;
      fsgs_pkg::ST_CLR:    if (cur_r == LAST) state_nxt = fsgs_pkg::ST_DONE;
      fsgs_pkg::ST_REL_RD: state_nxt = fsgs_pkg::ST_REL_WR;
      fsgs_pkg::ST_REL_WR: state_nxt = (cur_r == LAST) ? fsgs_pkg::ST_DONE : fsgs_pkg::ST_REL_RD;
      fsgs_pkg::ST_SW_RD:  state_nxt = fsgs_pkg::ST_SW_CHK;
      fsgs_pkg::ST_SW_CHK: begin
        if (mem_rdata[1:0] == fsgs_pkg::KIND_EMPTY || mem_rdata[7]) begin
          state_nxt = (cur_r == '0) ? fsgs_pkg::ST_DONE : fsgs_pkg::ST_SW_RD;
        end else begin
          state_nxt = fsgs_pkg::ST_SW_NB;
        end
      end
      fsgs_pkg::ST_SW_NB:  if (slot_r == fsgs_pkg::SLOT_END) state_nxt = fsgs_pkg::ST_SW_DEC;
      fsgs_pkg::ST_SW_DEC: state_nxt = fsgs_pkg::ST_SW_WR;
      fsgs_pkg::ST_SW_WR: begin
        if (slot_r == fsgs_pkg::SLOT_RIGHT) begin
          state_nxt = (cur_r == '0) ? fsgs_pkg::ST_DONE : fsgs_pkg::ST_SW_RD;
        end
      end
      fsgs_pkg::ST_DONE:   if (out_free) state_nxt = fsgs_pkg::ST_IDLE;
      default:             state_nxt = fsgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur_r;
    mem_wdata = '0;
    unique case (state_r)
      fsgs_pkg::ST_INIT_CLR, fsgs_pkg::ST_CLR: begin
        mem_we = 1'b1;
      end
      fsgs_pkg::ST_IDLE: mem_addr = idx32[AW-1:0];
      fsgs_pkg::ST_CMD_WAIT: begin
        mem_addr  = idx_r;
        mem_we    = (func_r == fsgs_pkg::FUNC_WRITE) && idx_ok_r;
        mem_wdata = val_r;
      end
      fsgs_pkg::ST_REL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & fsgs_pkg::WALL_CLEAR;
      end
      fsgs_pkg::ST_SW_NB: mem_addr = slot_pos[AW-1:0];
      fsgs_pkg::ST_SW_WR: begin
        case (slot_r)
          fsgs_pkg::SLOT_BELOW: begin
            mem_we    = mv_r;
            mem_wdata = nb_r[tslot_r];
          end
          fsgs_pkg::SLOT_BL: begin
            mem_we    = mv_r;
            mem_addr  = tgt_pos[AW-1:0];
            mem_wdata = c_r;
          end
          default: begin
            mem_we    = soak_en && (c_r[1:0] == fsgs_pkg::KIND_WATER)
                        && !(mv_r && soak_pos == tgt_pos);
            mem_addr  = soak_pos[AW-1:0];
            mem_wdata = fsgs_pkg::soak_value(
                          nb_r[(soak_slot == fsgs_pkg::SLOT_BELOW) ? 0 :
                               (soak_slot == fsgs_pkg::SLOT_LEFT) ? 3 : 4], wet_r);
          end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsgs_pkg::ST_INIT_CLR;
      cur_r       <= '0;
      count_r     <= '0;
      wet_r       <= fsgs_pkg::WET_RESET;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        wet_r <= cfg_wet_colour;
      end
      if (state_r == fsgs_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        fsgs_pkg::ST_INIT_CLR, fsgs_pkg::ST_CLR: begin
          count_r <= '0;
          cur_r   <= cur_r + AW'(1);
        end
        fsgs_pkg::ST_IDLE: begin
          if (accept) begin
            func_r   <= in_func;
            idx_r    <= idx32[AW-1:0];
            idx_ok_r <= idx_ok;
            val_r    <= in_cell_value;
            rd_r     <= '0;
            cur_r    <= (in_func == fsgs_pkg::FUNC_SWEEP) ? LAST : '0;
          end
        end
        fsgs_pkg::ST_CMD_WAIT: begin
          if (idx_ok_r) begin
            if (func_r == fsgs_pkg::FUNC_READ) begin
              rd_r <= mem_rdata;
            end else begin
              count_r <= count_r
                         + CW'(val_r[1:0] != fsgs_pkg::KIND_EMPTY)
                         - CW'(mem_rdata[1:0] != fsgs_pkg::KIND_EMPTY);
            end
          end
        end
        fsgs_pkg::ST_REL_WR: cur_r <= cur_r + AW'(1);
        fsgs_pkg::ST_SW_CHK: begin
          c_r    <= mem_rdata;
          slot_r <= '0;
          if (mem_rdata[1:0] == fsgs_pkg::KIND_EMPTY || mem_rdata[7]) begin
            cur_r <= cur_r - AW'(1);
          end
        end
        fsgs_pkg::ST_SW_NB: begin
          prev_ok_r <= slot_ok;
          if (slot_r != '0) begin
            nb_r[slot_r - 3'd1]   <= prev_ok_r ? mem_rdata : fsgs_pkg::BLOCKED;
            nbok_r[slot_r - 3'd1] <= prev_ok_r;
          end
          slot_r <= (slot_r == fsgs_pkg::SLOT_END) ? '0 : slot_r + 3'd1;
        end
        fsgs_pkg::ST_SW_DEC: begin
          mv_r    <= mv;
          tslot_r <= tslot;
          slot_r  <= '0;
        end
        fsgs_pkg::ST_SW_WR: begin
          if (slot_r == fsgs_pkg::SLOT_RIGHT) begin
            slot_r <= '0;
            cur_r  <= cur_r - AW'(1);
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        fsgs_pkg::ST_DONE: begin
          if (out_free) begin
            out_read_value_r <= rd_r;
            out_grid_empty_r <= (count_r == '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_grid_empty = out_grid_empty_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("occupied count beyond grid size");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fsgs_pkg::ST_DONE))
    else $error("result raised outside completion");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsgs_pkg::ST_SW_NB || state_r == fsgs_pkg::ST_SW_WR) |-> !in_ready)
    else $error("input ready during sweep");
`endif

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 64;
  localparam int ROWS = 32;
  localparam int CELLS = COLS * ROWS;

  class sand_scoreboard;
    logic [7:0] grid [CELLS];
    int unsigned occupied;
    logic [3:0] wet;
    logic [7:0] want_read [$];
    logic want_empty [$];
    int mismatches;

    function void clear_all();
      for (int k = 0; k < CELLS; k++) grid[k] = 8'h00;
      occupied = 0;
    endfunction

    function logic [1:0] kind_of(int p);
      if (p < 0 || p >= CELLS) return 2'd3;
      return grid[p][1:0];
    endfunction

    function void swap_cells(int a, int b);
      logic [7:0] t;
      t = grid[a];
      grid[a] = grid[b];
      grid[b] = t;
    endfunction

    function void wet_sand(int p);
      if (kind_of(p) == fsgs_pkg::KIND_SAND)
        grid[p] = (grid[p] & fsgs_pkg::KEEP_MASK) | {2'b00, wet, 2'b00};
    endfunction

    function void fall_pass();
      logic [7:0] c;
      for (int i = CELLS - 1; i >= 0; i--) begin
        c = grid[i];
        if (c[1:0] == fsgs_pkg::KIND_EMPTY || c[7]) continue;
        if (c[1:0] == fsgs_pkg::KIND_SAND) begin
          if (i < CELLS - COLS) begin
            if (kind_of(i + COLS) == fsgs_pkg::KIND_EMPTY ||
                kind_of(i + COLS) == fsgs_pkg::KIND_WATER)
              swap_cells(i, i + COLS);
            else if (kind_of(i + COLS - 1) == fsgs_pkg::KIND_EMPTY)
              swap_cells(i, i + COLS - 1);
            else if (kind_of(i + COLS + 1) == fsgs_pkg::KIND_EMPTY)
              swap_cells(i, i + COLS + 1);
          end
        end else if (c[1:0] == fsgs_pkg::KIND_WATER) begin
          if (i < CELLS - COLS && kind_of(i + COLS) == fsgs_pkg::KIND_EMPTY)
            swap_cells(i, i + COLS);
          else if (i < CELLS - COLS && kind_of(i + COLS - 1) == fsgs_pkg::KIND_EMPTY)
            swap_cells(i, i + COLS - 1);
          else if (i < CELLS - COLS && kind_of(i + COLS + 1) == fsgs_pkg::KIND_EMPTY)
            swap_cells(i, i + COLS + 1);
          else if (kind_of(i - 1) == fsgs_pkg::KIND_EMPTY) swap_cells(i, i - 1);
          else if (kind_of(i + 1) == fsgs_pkg::KIND_EMPTY) swap_cells(i, i + 1);
          wet_sand(i + COLS);
          wet_sand(i - 1);
          wet_sand(i + 1);
        end
      end
    endfunction

    function void note_command(fsgs_pkg::func_t f, logic [10:0] idx, logic [7:0] val);
      logic [7:0] rd;
      rd = 8'h00;
      case (f)
        fsgs_pkg::FUNC_WRITE: begin
          if (idx < CELLS) begin
            if (grid[idx][1:0] != fsgs_pkg::KIND_EMPTY) occupied--;
            grid[idx] = val;
            if (val[1:0] != fsgs_pkg::KIND_EMPTY) occupied++;
          end
        end
        fsgs_pkg::FUNC_READ: if (idx < CELLS) rd = grid[idx];
        fsgs_pkg::FUNC_SWEEP: fall_pass();
        fsgs_pkg::FUNC_CLEAR: clear_all();
        fsgs_pkg::FUNC_RELEASE:
          for (int k = 0; k < CELLS; k++) grid[k] = grid[k] & fsgs_pkg::WALL_CLEAR;
        default: ;
      endcase
      want_read.push_back(rd);
      want_empty.push_back(occupied == 0);
    endfunction

    function void check_result(logic [7:0] rd, logic em);
      logic [7:0] er;
      logic ee;
      if (want_read.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result read=%h empty=%b", rd, em);
        return;
      end
      er = want_read.pop_front();
      ee = want_empty.pop_front();
      if (rd !== er || em !== ee) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch read exp %h got %h, empty exp %b got %b", er, rd, ee, em);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_func = '0;
  logic [10:0] in_cell_index = '0;
  logic [7:0] in_cell_value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [7:0] out_read_value;
  logic out_grid_empty;
  logic cfg_we = 0;
  logic [3:0] cfg_wet_colour = '0;

  sand_scoreboard sb;
  bit stall_long = 0;

  always #5 clk = ~clk;

  falling_sand_grid_step_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_cell_index(in_cell_index), .in_cell_value(in_cell_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_value(out_read_value), .out_grid_empty(out_grid_empty),
    .cfg_we(cfg_we), .cfg_wet_colour(cfg_wet_colour)
  );

  task automatic send_command(fsgs_pkg::func_t f, logic [10:0] idx, logic [7:0] val);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_cell_index <= idx;
    in_cell_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_command(f, idx, val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.want_read.size() != 0) @(posedge clk);
    repeat (30000) @(posedge clk);
  endtask

  task automatic set_wet(logic [3:0] c);
    cfg_we <= 1'b1;
    cfg_wet_colour <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.wet = c;
  endtask

  function automatic logic [7:0] cell_byte();
    logic [7:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) v[7] = 1'b0;
    return v;
  endfunction

  task automatic random_commands(int count);
    int r;
    logic [10:0] idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      idx = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 3 * COLS));
      if (r < 55) send_command(fsgs_pkg::FUNC_WRITE, idx, cell_byte());
      else if (r < 75) send_command(fsgs_pkg::FUNC_READ, idx, 8'($urandom));
      else if (r < 88) send_command(fsgs_pkg::FUNC_SWEEP, 11'($urandom), 8'($urandom));
      else if (r < 92) send_command(fsgs_pkg::FUNC_RELEASE, idx, 8'($urandom));
      else if (r < 95) send_command(fsgs_pkg::FUNC_CLEAR, idx, 8'($urandom));
      else send_command(fsgs_pkg::func_t'($urandom_range(5, 7)), idx, 8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_read_value, out_grid_empty);
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (stall_long) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        stall_long = 0;
      end else if (out_ready && out_valid) begin
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
          @(posedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    sb.clear_all();
    sb.wet = fsgs_pkg::WET_RESET;
    sb.mismatches = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_command(fsgs_pkg::FUNC_WRITE, 11'd0, 8'hff);
    send_command(fsgs_pkg::FUNC_READ, 11'd0, 8'h00);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd2047, 8'h01);
    send_command(fsgs_pkg::FUNC_READ, 11'd2047, 8'h00);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd2047, 8'h00);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd2046, 8'h01);
    send_command(fsgs_pkg::FUNC_READ, 11'd2046, 8'h00);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd70, 8'h01);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd134, 8'h02);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd64, 8'h01);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd128, 8'h83);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd133, 8'h81);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd1990, 8'h02);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd1989, 8'h05);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd63, 8'h02);
    send_command(fsgs_pkg::FUNC_WRITE, 11'd300, 8'h03);
    send_command(fsgs_pkg::FUNC_SWEEP, 11'd0, 8'h00);
    send_command(fsgs_pkg::FUNC_READ, 11'd134, 8'h00);
    send_command(fsgs_pkg::FUNC_READ, 11'd1989, 8'h00);
    send_command(fsgs_pkg::FUNC_READ, 11'd300, 8'h00);
    send_command(fsgs_pkg::FUNC_RELEASE, 11'd0, 8'h00);
    send_command(fsgs_pkg::FUNC_SWEEP, 11'd0, 8'h00);
    send_command(fsgs_pkg::FUNC_READ, 11'd0, 8'h00);
    send_command(fsgs_pkg::func_t'(3'd7), 11'd0, 8'h00);
    send_command(fsgs_pkg::FUNC_CLEAR, 11'd0, 8'h00);
    send_command(fsgs_pkg::FUNC_READ, 11'd0, 8'h00);

    wait_drained();
    set_wet(4'hf);
    stall_long = 1;
    random_commands(30);
    wait_drained();
    set_wet(4'h0);
    random_commands(35);
    wait_drained();
    set_wet(4'ha);
    random_commands(35);
    in_valid <= 1'b0;

    while (sb.want_read.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.want_read.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
